@@ rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants for the cache tag lookup core
// Entry layout, register indexes, channel widths and sequencer states.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int SET_OUT_W  = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAY_BITS    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_LRU  = 8'd3;

  localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
  localparam logic [3:0] RST_LINE_BITS   = 4'd8;
  localparam logic [3:0] RST_WAY_BITS    = 4'd0;
  localparam logic       RST_POLICY_LRU  = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic start;
    logic sample;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

@@ rtl/sacl_if.sv @@
// ----------------------------------------------------------------------------
// sacl_if: channel interfaces of the cache tag lookup core
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sacl_req_if;
  logic                        valid;
  logic                        ready;
  logic [sacl_pkg::ADDR_W-1:0] address;
  modport source(output valid, output address, input ready);
  modport sink(input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [sacl_pkg::TAG_W-1:0]     tag_value;
  logic [sacl_pkg::SET_OUT_W-1:0] set_number;
  logic                           evicted_valid;
  logic [sacl_pkg::TAG_W-1:0]     evicted_tag;
  logic [sacl_pkg::CNT_W-1:0]     hit_count;
  logic [sacl_pkg::CNT_W-1:0]     miss_count;
  logic [sacl_pkg::CNT_W-1:0]     access_count;
  modport source(output valid, output hit, output tag_value, output set_number,
                 output evicted_valid, output evicted_tag, output hit_count,
                 output miss_count, output access_count, input ready);
  modport sink(input valid, input hit, input tag_value, input set_number,
               input evicted_valid, input evicted_tag, input hit_count,
               input miss_count, input access_count, output ready);
endinterface

interface sacl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  index;
  logic [sacl_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/sacl_scan.sv @@
// ----------------------------------------------------------------------------
// sacl_scan: per-way compare unit of the tag lookup
// Takes one way entry per cycle while sample is set and tracks first match,
// first free way and the way with the oldest stamp (lowest index on a tie).
// ----------------------------------------------------------------------------
module sacl_scan #(
  parameter int IDX_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sacl_pkg::scan_ctl_t        ctl,
  input  logic [IDX_W-1:0]           way,
  input  sacl_pkg::entry_t           entry,
  input  logic [sacl_pkg::TAG_W-1:0] tag,
  output sacl_pkg::scan_res_t        res,
  output logic [IDX_W-1:0]           hit_way,
  output logic [IDX_W-1:0]           free_way,
  output logic [IDX_W-1:0]           min_way,
  output logic [sacl_pkg::TAG_W-1:0] min_tag
);

  logic [sacl_pkg::CNT_W-1:0] min_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (ctl.start) begin
      res <= '0;
    end else if (ctl.sample) begin
      if (entry.valid && (entry.tag == tag) && !res.hit) begin
        res.hit <= 1'b1;
      end
      if (!entry.valid && !res.free) begin
        res.free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      if (entry.valid && (entry.tag == tag) && !res.hit) begin
        hit_way <= way;
      end
      if (!entry.valid && !res.free) begin
        free_way <= way;
      end
      if ((way == '0) || (entry.stamp < min_stamp)) begin
        min_stamp <= entry.stamp;
        min_way   <= way;
        min_tag   <= entry.tag;
      end
    end
  end

endmodule

@@ rtl/set_assoc_cache_tag_lookup_core.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core: set-associative cache tag lookup
// Looks up one address per transaction, fills or replaces a line (FIFO or
// LRU) and reports hit, eviction and saturating hit/miss/access counts.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one byte address per transaction.
//   rsp  : one result per request: hit, tag, set, eviction, three counters.
//   cfg  : register writes (0 offset_bits, 1 line_bits, 2 way_bits,
//          3 policy_lru); always ready, other indexes ignored. Write only
//          while no request is in flight.
//   Ways per set: W = 2^min(way_bits, eff line_bits). The scan reads one
//   way per cycle from the line memory (separate read and write ports);
//   a request goes through SCAN, DRAIN and DONE, where the result is
//   loaded, and the next request is accepted only once it is back in IDLE.
//   Reset: registers take their reset values and a clearing sweep over all
//   MAX_LINES lines invalidates every line; req.ready stays low meanwhile.
//   Stall: the result is held in the output register. The next request is
//   accepted and scanned, then waits in its final step until rsp is free.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_core #(
  parameter int MAX_LINES  = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  sacl_req_if.sink          req,
  sacl_rsp_if.source        rsp,
  sacl_cfg_if.sink          cfg
);

  localparam int LOG_LINES = $clog2(MAX_LINES + 1) - 1;
  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LINES - 1);
  localparam logic [4:0] LOG_LINES_V = 5'(LOG_LINES);
  localparam logic [sacl_pkg::ADDR_W-1:0] AMASK =
    (ADDR_WIDTH >= sacl_pkg::ADDR_W) ? '1 : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  // configuration
  logic [4:0] offset_bits;
  logic [3:0] line_bits;
  logic [3:0] way_bits;
  logic       policy_lru;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= sacl_pkg::RST_OFFSET_BITS;
      line_bits   <= sacl_pkg::RST_LINE_BITS;
      way_bits    <= sacl_pkg::RST_WAY_BITS;
      policy_lru  <= sacl_pkg::RST_POLICY_LRU;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sacl_pkg::REG_OFFSET_BITS: offset_bits <= cfg.data[4:0];
        sacl_pkg::REG_LINE_BITS:   line_bits   <= cfg.data[3:0];
        sacl_pkg::REG_WAY_BITS:    way_bits    <= cfg.data[3:0];
        sacl_pkg::REG_POLICY_LRU:  policy_lru  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // address split
  logic [4:0]                  lb;
  logic [4:0]                  wb;
  logic [4:0]                  sb;
  logic [5:0]                  tag_sh;
  logic [sacl_pkg::ADDR_W-1:0] addr_m;
  logic [sacl_pkg::TAG_W-1:0]  tag_calc;
  logic [IDX_W-1:0]            set_calc;
  logic [IDX_W-1:0]            wlast_calc;

  always_comb begin
    lb = ({1'b0, line_bits} > LOG_LINES_V) ? LOG_LINES_V : {1'b0, line_bits};
    wb = ({1'b0, way_bits} > lb) ? lb : {1'b0, way_bits};
    sb = lb - wb;
    addr_m = req.address & AMASK;
    tag_sh = {1'b0, offset_bits} + {1'b0, sb};
    tag_calc = addr_m >> tag_sh;
    set_calc = IDX_W'((addr_m >> offset_bits) & ((32'd1 << sb) - 32'd1));
    wlast_calc = IDX_W'((17'd1 << wb) - 17'd1);
  end

  // sequencer state
  sacl_pkg::state_t            state;
  sacl_pkg::state_t            state_next;
  logic [IDX_W-1:0]            cnt;
  logic [sacl_pkg::TAG_W-1:0]  tag_q;
  logic [IDX_W-1:0]            set_q;
  logic [4:0]                  wb_q;
  logic [IDX_W-1:0]            wlast_q;
  logic [sacl_pkg::CNT_W-1:0]  now_q;
  logic [sacl_pkg::CNT_W-1:0]  hits_total;
  logic [sacl_pkg::CNT_W-1:0]  misses_total;
  logic [sacl_pkg::CNT_W-1:0]  accesses_total;
  logic                        rd_vld;
  logic [IDX_W-1:0]            rd_way;

  logic accept;
  logic out_free;
  logic load;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;

  // memory and scan unit
  sacl_pkg::entry_t mem [MAX_LINES];
  sacl_pkg::entry_t rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  sacl_pkg::entry_t wr_entry;
  logic [IDX_W-1:0] base;

  sacl_pkg::scan_ctl_t scan_ctl;
  sacl_pkg::scan_res_t scan_res;
  logic [IDX_W-1:0]           hit_way;
  logic [IDX_W-1:0]           free_way;
  logic [IDX_W-1:0]           min_way;
  logic [sacl_pkg::TAG_W-1:0] min_tag;
  logic [IDX_W-1:0]           victim;

  assign base     = IDX_W'(set_q << wb_q);
  assign rd_addr  = base | cnt;
  assign victim   = scan_res.free ? free_way : min_way;
  assign scan_ctl = '{start: accept, sample: rd_vld};

  sacl_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .way      (rd_way),
    .entry    (rd_q),
    .tag      (tag_q),
    .res      (scan_res),
    .hit_way  (hit_way),
    .free_way (free_way),
    .min_way  (min_way),
    .min_tag  (min_tag)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sacl_pkg::ST_CLEAR: if (cnt == LAST_IDX) state_next = sacl_pkg::ST_IDLE;
      sacl_pkg::ST_IDLE:  if (req.valid) state_next = sacl_pkg::ST_SCAN;
      sacl_pkg::ST_SCAN:  if (cnt == wlast_q) state_next = sacl_pkg::ST_DRAIN;
      sacl_pkg::ST_DRAIN: state_next = sacl_pkg::ST_DONE;
      sacl_pkg::ST_DONE:  if (out_free) state_next = sacl_pkg::ST_IDLE;
      default:            state_next = sacl_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    load      = 1'b0;
    mem_we    = 1'b0;
    wr_addr   = cnt;
    wr_entry  = '0;
    unique case (state)
      sacl_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      sacl_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      sacl_pkg::ST_DONE: begin
        load     = out_free;
        mem_we   = out_free && (!scan_res.hit || policy_lru);
        wr_addr  = base | (scan_res.hit ? hit_way : victim);
        wr_entry = '{valid: 1'b1, tag: tag_q, stamp: now_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sacl_pkg::ST_CLEAR;
      cnt            <= '0;
      rd_vld         <= 1'b0;
      accesses_total <= '0;
      hits_total     <= '0;
      misses_total   <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == sacl_pkg::ST_SCAN);
      rd_way <= cnt;
      unique case (state)
        sacl_pkg::ST_CLEAR: cnt <= (cnt == LAST_IDX) ? '0 : cnt + 1'b1;
        sacl_pkg::ST_SCAN:  if (cnt != wlast_q) cnt <= cnt + 1'b1;
        default:            cnt <= '0;
      endcase
      if (accept) begin
        accesses_total <= sacl_pkg::sat_inc(accesses_total);
      end
      if (load) begin
        if (scan_res.hit) hits_total <= sacl_pkg::sat_inc(hits_total);
        else misses_total <= sacl_pkg::sat_inc(misses_total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q   <= tag_calc;
      set_q   <= set_calc;
      wb_q    <= wb;
      wlast_q <= wlast_calc;
      now_q   <= sacl_pkg::sat_inc(accesses_total);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.hit           <= scan_res.hit;
      rsp.tag_value     <= tag_q;
      rsp.set_number    <= 8'(set_q);
      rsp.evicted_valid <= !scan_res.hit && !scan_res.free;
      rsp.evicted_tag   <= (!scan_res.hit && !scan_res.free) ? min_tag : '0;
      rsp.hit_count     <= scan_res.hit ? sacl_pkg::sat_inc(hits_total) : hits_total;
      rsp.miss_count    <= scan_res.hit ? misses_total : sacl_pkg::sat_inc(misses_total);
      rsp.access_count  <= accesses_total;
    end
  end

  // checks
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == sacl_pkg::ST_SCAN))
    else $error("accepted request did not start a scan");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.evicted_valid) |-> !rsp.hit)
    else $error("eviction reported on a hit");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.access_count == sacl_pkg::CNT_MAX) ||
                   (({1'b0, rsp.hit_count} + {1'b0, rsp.miss_count}) ==
                    {1'b0, rsp.access_count})))
    else $error("hit and miss counts do not add up to access count");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == sacl_pkg::ST_CLEAR) || (state == sacl_pkg::ST_DONE)))
    else $error("line memory written outside clear or update");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == sacl_pkg::ST_CLEAR) |=> !$past(accept))
    else $error("request accepted during clearing sweep");

endmodule
